// ===== src/gvw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gvw_pkg
// Shared types and codes for the grid vertex weld block.
// ----------------------------------------------------------------------------
package gvw_pkg;

	localparam int unsigned COORD_W = 32;
	localparam int unsigned SCALE_W = 17;
	localparam int unsigned SRC_W   = 10;
	localparam int unsigned IDX_W   = 10;
	localparam int unsigned EPOCH_W = 8;

	localparam logic [SCALE_W-1:0] SCALE_MAX = 17'd65536;
	localparam logic [SCALE_W-1:0] SCALE_RST = 17'd10000;
	localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;

	localparam logic KIND_POINT = 1'b0;
	localparam logic KIND_TRI   = 1'b1;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_FULL     = 2'd1;
	localparam logic [1:0] STATUS_UNLOADED = 2'd2;

	typedef struct packed {
		logic               kind;
		logic               restart;
		logic [COORD_W-1:0] coord_x;
		logic [COORD_W-1:0] coord_y;
		logic [COORD_W-1:0] coord_z;
		logic [SRC_W-1:0]   src_a;
		logic [SRC_W-1:0]   src_b;
		logic [SRC_W-1:0]   src_c;
	} gvw_req_t;

	typedef struct packed {
		logic             result_kind;
		logic [IDX_W-1:0] welded_index;
		logic             is_new;
		logic [IDX_W-1:0] tri_a;
		logic [IDX_W-1:0] tri_b;
		logic [IDX_W-1:0] tri_c;
		logic [1:0]       status;
	} gvw_res_t;

endpackage
`default_nettype wire

// ===== src/grid_vertex_weld.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// grid_vertex_weld
// Vertex welding on a quantized grid with a linear-probe hash table, and
// triangle remapping through the source-to-welded map.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the request is finished. The result, if any, shows on rsp for one
// cycle with rsp_valid, and the receiver cannot stall it. A point computes
// three keys one after another through one multiplier and rounding step,
// then probes hash slots, with one read of the slot memory and one compare
// per probe. A triangle takes three reads of the source map, one per corner.
// A point refused because the source map is full, and a triangle with an
// unloaded corner, finish in the dispatch state. After reset the block is
// busy while it clears the slot table; a restart is otherwise free, except
// every 255th, which repeats that clearing pass.
// ----------------------------------------------------------------------------
module grid_vertex_weld import gvw_pkg::*; #(
	parameter int unsigned MAX_POINTS = 1024,
	parameter int unsigned HASH_SLOTS = 2048
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [SCALE_W-1:0] cfg_wdata,
	input  wire logic               start,
	output logic                    busy,
	input  wire gvw_req_t           req,
	output logic                    rsp_valid,
	output gvw_res_t                rsp
);

	localparam int unsigned PW  = $clog2(MAX_POINTS);
	localparam int unsigned CW  = $clog2(MAX_POINTS + 1);
	localparam int unsigned SW  = $clog2(HASH_SLOTS);
	localparam int unsigned HW  = $clog2(HASH_SLOTS + 1);
	localparam int unsigned XW  = (CW > SRC_W) ? CW : SRC_W;
	localparam int unsigned HPW = 16 + HW;

	typedef struct packed {
		logic [EPOCH_W-1:0] tag;
		logic [COORD_W-1:0] kx;
		logic [COORD_W-1:0] ky;
		logic [COORD_W-1:0] kz;
		logic [PW-1:0]      widx;
	} slot_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLEAR, ST_DISPATCH, ST_MUL, ST_RND, ST_HASH,
		ST_PROBE, ST_CMP, ST_TRD, ST_TCAP, ST_TCHK
	} state_t;

	function automatic logic [IDX_W-1:0] to_idx(input logic [PW-1:0] v);
		logic [XW-1:0] t;
		t = XW'(v);
		return t[IDX_W-1:0];
	endfunction

	function automatic logic [PW-1:0] to_map_addr(input logic [SRC_W-1:0] v);
		logic [XW-1:0] t;
		t = XW'(v);
		return t[PW-1:0];
	endfunction

	state_t             state_q;
	logic [SCALE_W-1:0] grid_scale_q;
	gvw_req_t           req_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic               run_after_clr_q;
	logic [SW-1:0]      clr_q;
	logic [CW-1:0]      src_cnt_q;
	logic [CW-1:0]      weld_cnt_q;
	logic [1:0]         axis_q;
	logic [COORD_W-1:0] key_q [3];
	logic [SW-1:0]      slot_q;
	logic [HW-1:0]      probe_q;
	logic [1:0]         corner_sel_q;
	logic [PW-1:0]      corner_q [3];
	logic               rsp_valid_q;
	gvw_res_t           rsp_q;

	slot_t              slot_mem [HASH_SLOTS];
	slot_t              slot_rd_q;
	logic               slot_we;
	logic [SW-1:0]      slot_wa;
	slot_t              slot_wd;

	logic [PW-1:0]      map_mem [MAX_POINTS];
	logic [PW-1:0]      map_rd_q;
	logic               map_we;
	logic [PW-1:0]      map_ra;

	logic [SCALE_W-1:0] scale_eff;
	logic [COORD_W-1:0] coord_sel;
	logic [COORD_W-1:0] key_out;
	logic [COORD_W-1:0] fold32;
	logic [15:0]        fold16;
	logic [HPW-1:0]     home_prod;
	logic               slot_live;
	logic               slot_hit;
	logic               src_bad;
	logic [SRC_W-1:0]   src_sel;

	assign busy      = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign scale_eff = (grid_scale_q > SCALE_MAX) ? SCALE_MAX : grid_scale_q;

	always_comb begin
		case (axis_q)
			2'd0:    coord_sel = req_q.coord_x;
			2'd1:    coord_sel = req_q.coord_y;
			default: coord_sel = req_q.coord_z;
		endcase
	end

	gvw_key_unit u_key (
		.clk   (clk),
		.coord (coord_sel),
		.scale (scale_eff),
		.key   (key_out)
	);

	assign fold32    = key_q[0] ^ {key_q[1][20:0], key_q[1][31:21]}
		^ {key_q[2][9:0], key_q[2][31:10]};
	assign fold16    = fold32[31:16] ^ fold32[15:0];
	assign home_prod = HPW'(fold16) * HPW'(HASH_SLOTS);

	assign slot_live = (slot_rd_q.tag == epoch_q);
	assign slot_hit  = slot_live && (slot_rd_q.kx == key_q[0])
		&& (slot_rd_q.ky == key_q[1]) && (slot_rd_q.kz == key_q[2]);

	assign src_bad = (XW'(req_q.src_a) >= XW'(src_cnt_q))
		|| (XW'(req_q.src_b) >= XW'(src_cnt_q))
		|| (XW'(req_q.src_c) >= XW'(src_cnt_q));

	always_comb begin
		case (corner_sel_q)
			2'd0:    src_sel = req_q.src_a;
			2'd1:    src_sel = req_q.src_b;
			default: src_sel = req_q.src_c;
		endcase
	end
	assign map_ra = to_map_addr(src_sel);

	always_comb begin
		slot_we      = 1'b0;
		slot_wa      = slot_q;
		slot_wd.tag  = epoch_q;
		slot_wd.kx   = key_q[0];
		slot_wd.ky   = key_q[1];
		slot_wd.kz   = key_q[2];
		slot_wd.widx = weld_cnt_q[PW-1:0];
		map_we       = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				slot_we     = 1'b1;
				slot_wa     = clr_q;
				slot_wd.tag = '0;
			end
			ST_CMP: begin
				if (slot_hit) begin
					map_we = 1'b1;
				end else if (!slot_live && (weld_cnt_q < CW'(MAX_POINTS))) begin
					slot_we = 1'b1;
					map_we  = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_wa] <= slot_wd;
		end
		slot_rd_q <= slot_mem[slot_q];
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[src_cnt_q[PW-1:0]] <= slot_hit ? slot_rd_q.widx : weld_cnt_q[PW-1:0];
		end
		map_rd_q <= map_mem[map_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_scale_q <= SCALE_RST;
		end else if (cfg_we) begin
			grid_scale_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			req_q <= req;
		end
		if (state_q == ST_RND) begin
			key_q[axis_q] <= key_out;
		end
		if (state_q == ST_TCAP) begin
			corner_q[corner_sel_q] <= map_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_CLEAR;
			epoch_q         <= EPOCH_FIRST;
			run_after_clr_q <= 1'b0;
			clr_q           <= '0;
			src_cnt_q       <= '0;
			weld_cnt_q      <= '0;
			axis_q          <= '0;
			slot_q          <= '0;
			probe_q         <= '0;
			corner_sel_q    <= '0;
			rsp_valid_q     <= 1'b0;
			rsp_q           <= '0;
		end else begin
			rsp_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						rsp_q <= '0;
						if (req.restart) begin
							src_cnt_q  <= '0;
							weld_cnt_q <= '0;
							if (epoch_q == EPOCH_MAX) begin
								clr_q           <= '0;
								run_after_clr_q <= 1'b1;
								state_q         <= ST_CLEAR;
							end else begin
								epoch_q <= epoch_q + 1'b1;
								state_q <= ST_DISPATCH;
							end
						end else begin
							state_q <= ST_DISPATCH;
						end
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SW'(HASH_SLOTS - 1)) begin
						epoch_q <= EPOCH_FIRST;
						state_q <= run_after_clr_q ? ST_DISPATCH : ST_IDLE;
					end
				end
				ST_DISPATCH: begin
					axis_q       <= '0;
					corner_sel_q <= '0;
					if (req_q.kind == KIND_POINT) begin
						rsp_q.result_kind <= KIND_POINT;
						if (src_cnt_q >= CW'(MAX_POINTS)) begin
							rsp_q.status <= STATUS_FULL;
							rsp_valid_q  <= 1'b1;
							state_q      <= ST_IDLE;
						end else begin
							state_q <= ST_MUL;
						end
					end else begin
						rsp_q.result_kind <= KIND_TRI;
						if (src_bad) begin
							rsp_q.status <= STATUS_UNLOADED;
							rsp_valid_q  <= 1'b1;
							state_q      <= ST_IDLE;
						end else begin
							state_q <= ST_TRD;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_RND;
				end
				ST_RND: begin
					if (axis_q == 2'd2) begin
						state_q <= ST_HASH;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_HASH: begin
					slot_q  <= home_prod[16+SW-1:16];
					probe_q <= '0;
					state_q <= ST_PROBE;
				end
				ST_PROBE: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (slot_hit) begin
						rsp_q.welded_index <= to_idx(slot_rd_q.widx);
						src_cnt_q          <= src_cnt_q + 1'b1;
						rsp_valid_q        <= 1'b1;
						state_q            <= ST_IDLE;
					end else if (!slot_live) begin
						if (weld_cnt_q >= CW'(MAX_POINTS)) begin
							rsp_q.status <= STATUS_FULL;
						end else begin
							rsp_q.welded_index <= to_idx(weld_cnt_q[PW-1:0]);
							rsp_q.is_new       <= 1'b1;
							src_cnt_q          <= src_cnt_q + 1'b1;
							weld_cnt_q         <= weld_cnt_q + 1'b1;
						end
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else if (probe_q + 1'b1 == HW'(HASH_SLOTS)) begin
						rsp_q.status <= STATUS_FULL;
						rsp_valid_q  <= 1'b1;
						state_q      <= ST_IDLE;
					end else begin
						probe_q <= probe_q + 1'b1;
						slot_q  <= (slot_q == SW'(HASH_SLOTS - 1)) ? '0 : slot_q + 1'b1;
						state_q <= ST_PROBE;
					end
				end
				ST_TRD: begin
					state_q <= ST_TCAP;
				end
				ST_TCAP: begin
					if (corner_sel_q == 2'd2) begin
						state_q <= ST_TCHK;
					end else begin
						corner_sel_q <= corner_sel_q + 1'b1;
						state_q      <= ST_TRD;
					end
				end
				ST_TCHK: begin
					if ((corner_q[0] != corner_q[1]) && (corner_q[1] != corner_q[2])
						&& (corner_q[2] != corner_q[0])) begin
						rsp_q.tri_a <= to_idx(corner_q[0]);
						rsp_q.tri_b <= to_idx(corner_q[1]);
						rsp_q.tri_c <= to_idx(corner_q[2]);
						rsp_valid_q <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== src/gvw_key_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gvw_key_unit
// Shared grid key unit: |coord| * scale registered, then rounded half away
// from zero, shifted down by 16 and given the sign of the coordinate.
// ----------------------------------------------------------------------------
module gvw_key_unit import gvw_pkg::*; (
	input  wire logic               clk,
	input  wire logic [COORD_W-1:0] coord,
	input  wire logic [SCALE_W-1:0] scale,
	output logic      [COORD_W-1:0] key
);

	localparam int unsigned PROD_W = COORD_W + SCALE_W;

	logic [COORD_W-1:0] mag;
	logic [PROD_W-1:0]  prod_s1;
	logic               neg_s1;
	logic [PROD_W-1:0]  sum;
	logic [COORD_W-1:0] q;

	assign mag = coord[COORD_W-1] ? (~coord + 1'b1) : coord;

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(mag) * PROD_W'(scale);
		neg_s1  <= coord[COORD_W-1];
	end

	assign sum = prod_s1 + PROD_W'(32768);
	assign q   = sum[COORD_W+15:16];
	assign key = neg_s1 ? (~q + 1'b1) : q;

endmodule
`default_nettype wire

// ===== src/gvw_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gvw_checker
// Port-level checks on the grid vertex weld block, bound to its top level.
// ----------------------------------------------------------------------------
module gvw_checker import gvw_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     start,
	input wire logic     busy,
	input wire logic     rsp_valid,
	input wire gvw_res_t rsp
);

	// a request passes through dispatch before its result, so strobes never abut
	a_rsp_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |=> !rsp_valid)
		else $error("back-to-back result strobes");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low after request taken");

	a_full_is_point: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == STATUS_FULL) |->
		(rsp.result_kind == KIND_POINT && rsp.welded_index == '0 && !rsp.is_new))
		else $error("capacity result malformed");

	a_tri_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.result_kind == KIND_TRI) |->
		(!rsp.is_new && rsp.welded_index == '0 && rsp.status != STATUS_FULL))
		else $error("triangle result carries point fields");

	a_tri_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.result_kind == KIND_TRI && rsp.status == STATUS_OK) |->
		(rsp.tri_a != rsp.tri_b && rsp.tri_b != rsp.tri_c && rsp.tri_c != rsp.tri_a))
		else $error("degenerate triangle emitted");

endmodule

bind grid_vertex_weld gvw_checker u_gvw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.rsp_valid (rsp_valid),
	.rsp       (rsp)
);
`default_nettype wire
